// File: rtl/cstr_pkg.sv
// shared types and character codes for the comment stripper
// no dependencies
package cstr_pkg;

    localparam int PEND_W = 6;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_SQ    = 8'd39;
    localparam logic [7:0] CH_DQ    = 8'd34;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_BSL   = 8'd92;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       empty_res;
        logic       last;
    } out_item_t;

    // one accepted byte worth of output work
    typedef struct packed {
        logic              pre_v;
        logic [7:0]        pre_b;
        logic [PEND_W-1:0] nl_cnt;
        logic              main_v;
        logic [7:0]        main_b;
        logic              tail_v;
        logic [7:0]        tail_b;
        logic              last;
    } cmd_t;

endpackage

// File: rtl/cstr_stream_if.sv
// valid/ready stream channel with a typed payload
// no dependencies
interface cstr_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/cstr_front.sv
// front end: scan state, literal tracking and splice count, builds one command per byte
// depends on cstr_pkg, cstr_stream_if
module cstr_front #(
    parameter int PENDING_LIMIT = 62
) (
    input  logic                 clk,
    input  logic                 rst_n,
    cstr_stream_if.sink          feed,
    input  logic                 full,
    output logic                 push,
    output cstr_pkg::cmd_t       cmd
);
    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_LINE   = 2'd1;
    localparam logic [1:0] MODE_BLOCK  = 2'd2;
    localparam logic [1:0] MODE_STAR   = 2'd3;

    localparam logic [1:0] HOLD_NONE  = 2'd0;
    localparam logic [1:0] HOLD_SLASH = 2'd1;
    localparam logic [1:0] HOLD_BSL   = 2'd2;

    localparam logic [cstr_pkg::PEND_W-1:0] LIMIT = cstr_pkg::PEND_W'(PENDING_LIMIT);

    logic [1:0]                   mode_reg, mode_next;
    logic [1:0]                   held_reg, held_next;
    logic                         dq_reg, dq_next;
    logic                         sq_reg, sq_next;
    logic [cstr_pkg::PEND_W-1:0]  pend_reg, pend_next;

    logic       accept;
    logic [7:0] c;
    logic       eot;
    logic       fresh;
    logic       outside;

    assign feed.ready = !full;
    assign accept     = feed.valid && !full;
    assign c          = feed.data.in_byte;
    assign eot        = feed.data.end_of_text;
    assign outside    = !dq_reg && !sq_reg;

    always_comb
    begin
        mode_next = mode_reg;
        held_next = held_reg;
        dq_next   = dq_reg;
        sq_next   = sq_reg;
        pend_next = pend_reg;
        cmd       = '0;
        fresh     = 1'b0;

        unique case (mode_reg)
            MODE_LINE:
            begin
                if (c == cstr_pkg::CH_NL)
                begin
                    cmd.main_v = 1'b1;
                    cmd.main_b = cstr_pkg::CH_NL;
                    mode_next  = MODE_NORMAL;
                end
            end
            MODE_BLOCK:
            begin
                if (c == cstr_pkg::CH_NL)
                begin
                    cmd.main_v = 1'b1;
                    cmd.main_b = cstr_pkg::CH_NL;
                end
                else if (c == cstr_pkg::CH_STAR)
                begin
                    mode_next = MODE_STAR;
                end
            end
            MODE_STAR:
            begin
                if (c == cstr_pkg::CH_SLASH)
                begin
                    mode_next = MODE_NORMAL;
                end
                else if (c != cstr_pkg::CH_STAR)
                begin
                    if (c == cstr_pkg::CH_NL)
                    begin
                        cmd.main_v = 1'b1;
                        cmd.main_b = cstr_pkg::CH_NL;
                    end
                    mode_next = MODE_BLOCK;
                end
            end
            MODE_NORMAL:
            begin
                held_next = HOLD_NONE;
                if (held_reg == HOLD_BSL)
                begin
                    if (c == cstr_pkg::CH_NL)
                    begin
                        if (pend_reg < LIMIT)
                        begin
                            pend_next = pend_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        cmd.pre_v = 1'b1;
                        cmd.pre_b = cstr_pkg::CH_BSL;
                        fresh     = 1'b1;
                    end
                end
                else if (held_reg == HOLD_SLASH)
                begin
                    if (c == cstr_pkg::CH_SLASH)
                    begin
                        mode_next = MODE_LINE;
                    end
                    else if (c == cstr_pkg::CH_STAR)
                    begin
                        mode_next = MODE_BLOCK;
                    end
                    else
                    begin
                        cmd.pre_v = 1'b1;
                        cmd.pre_b = cstr_pkg::CH_SLASH;
                        fresh     = 1'b1;
                    end
                end
                else
                begin
                    fresh = 1'b1;
                end
            end
        endcase

        if (fresh)
        begin
            if (c == cstr_pkg::CH_BSL)
            begin
                held_next = HOLD_BSL;
            end
            else if (c == cstr_pkg::CH_SLASH && outside)
            begin
                held_next = HOLD_SLASH;
            end
            else
            begin
                if (c == cstr_pkg::CH_DQ && !sq_reg)
                begin
                    dq_next = !dq_reg;
                end
                else if (c == cstr_pkg::CH_SQ && !dq_reg)
                begin
                    sq_next = !sq_reg;
                end
                if (c == cstr_pkg::CH_NL)
                begin
                    dq_next    = 1'b0;
                    sq_next    = 1'b0;
                    cmd.nl_cnt = pend_reg;
                    pend_next  = '0;
                end
                cmd.main_v = 1'b1;
                cmd.main_b = c;
            end
        end

        if (eot)
        begin
            if (held_next == HOLD_BSL)
            begin
                cmd.tail_v = 1'b1;
                cmd.tail_b = cstr_pkg::CH_BSL;
            end
            else if (held_next == HOLD_SLASH)
            begin
                cmd.tail_v = 1'b1;
                cmd.tail_b = cstr_pkg::CH_SLASH;
            end
            if (mode_next == MODE_LINE)
            begin
                cmd.tail_v = 1'b1;
                cmd.tail_b = cstr_pkg::CH_NL;
            end
            cmd.last  = 1'b1;
            mode_next = MODE_NORMAL;
            held_next = HOLD_NONE;
            dq_next   = 1'b0;
            sq_next   = 1'b0;
            pend_next = '0;
        end
    end

    // bytes that produce nothing never enter the queue
    assign push = accept && (cmd.pre_v || cmd.main_v || cmd.tail_v || cmd.last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            held_reg <= HOLD_NONE;
            dq_reg   <= 1'b0;
            sq_reg   <= 1'b0;
            pend_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            dq_reg   <= dq_next;
            sq_reg   <= sq_next;
            pend_reg <= pend_next;
        end
    end
endmodule

// File: rtl/cstr_fifo.sv
// short command queue between front and back
// depends on cstr_pkg
module cstr_fifo #(
    parameter int DEPTH = 4
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cstr_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           avail,
    output cstr_pkg::cmd_t head
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cstr_pkg::cmd_t  mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == FULL_CNT);
    assign avail   = (cnt_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end
endmodule

// File: rtl/cstr_back.sv
// back end: expands each command into output beats through a registered output stage
// depends on cstr_pkg, cstr_stream_if
module cstr_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           avail,
    input  cstr_pkg::cmd_t head,
    output logic           pop,
    cstr_stream_if.source  result
);
    cstr_pkg::cmd_t              cur_reg, cur_next, after;
    logic                        emp_reg, emp_next;
    logic                        out_v_reg, out_v_next;
    cstr_pkg::out_item_t         out_reg, out_next;
    cstr_pkg::out_item_t         beat_item;
    logic                        busy;
    logic                        can_load;
    logic                        beat;
    logic                        done_after;

    assign busy     = cur_reg.pre_v || (cur_reg.nl_cnt != '0) || cur_reg.main_v
                      || cur_reg.tail_v || emp_reg;
    assign can_load = !out_v_reg || result.ready;
    assign beat     = busy && can_load;

    always_comb
    begin
        after     = cur_reg;
        beat_item = '0;
        if (cur_reg.pre_v)
        begin
            beat_item.out_byte = cur_reg.pre_b;
            after.pre_v        = 1'b0;
        end
        else if (cur_reg.nl_cnt != '0)
        begin
            beat_item.out_byte = cstr_pkg::CH_NL;
            after.nl_cnt       = cur_reg.nl_cnt - 1'b1;
        end
        else if (cur_reg.main_v)
        begin
            beat_item.out_byte = cur_reg.main_b;
            after.main_v       = 1'b0;
        end
        else if (cur_reg.tail_v)
        begin
            beat_item.out_byte = cur_reg.tail_b;
            after.tail_v       = 1'b0;
        end
        else
        begin
            beat_item.empty_res = 1'b1;
        end
        done_after     = !after.pre_v && (after.nl_cnt == '0) && !after.main_v
                         && !after.tail_v;
        beat_item.last = cur_reg.last && done_after;
    end

    assign pop = avail && (!busy || (beat && done_after));

    always_comb
    begin
        cur_next   = cur_reg;
        emp_next   = emp_reg;
        out_v_next = out_v_reg;
        out_next   = out_reg;
        if (result.ready)
        begin
            out_v_next = 1'b0;
        end
        if (beat)
        begin
            cur_next   = after;
            emp_next   = 1'b0;
            out_v_next = 1'b1;
            out_next   = beat_item;
        end
        if (pop)
        begin
            cur_next = head;
            emp_next = head.last && !head.pre_v && (head.nl_cnt == '0) && !head.main_v
                       && !head.tail_v;
        end
    end

    assign result.valid = out_v_reg;
    assign result.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= '0;
            emp_reg   <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            cur_reg   <= cur_next;
            emp_reg   <= emp_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end
endmodule

// File: rtl/c_comment_stripper.sv
// order: an accepted byte goes through the command queue, command register and output register
// throughput: one byte per cycle while the queue is not full; a byte's beats leave one at a time
// through the single output register, while the command queue absorbs short bursts
// reset: scan state, literal flags, splice count, queue and output stage clear; ready at once
// depends on cstr_pkg, cstr_stream_if, cstr_front, cstr_fifo, cstr_back
module c_comment_stripper #(
    parameter int PENDING_LIMIT = 62,
    parameter int QUEUE_DEPTH   = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    cstr_stream_if.sink   feed,
    cstr_stream_if.source result
);
    logic           full;
    logic           push;
    cstr_pkg::cmd_t push_cmd;
    logic           pop;
    logic           avail;
    cstr_pkg::cmd_t head;

    cstr_front #(
        .PENDING_LIMIT (PENDING_LIMIT)
    ) u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .feed  (feed),
        .full  (full),
        .push  (push),
        .cmd   (push_cmd)
    );

    cstr_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .avail    (avail),
        .head     (head)
    );

    cstr_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .avail  (avail),
        .head   (head),
        .pop    (pop),
        .result (result)
    );
endmodule
